// ===== rtl/cbr_pkg.sv =====
// Shared types and constants for the cube root bisection unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package cbr_pkg;

  // Width of the signed root and of the magnitude search.
  localparam int ROOT_BITS = 22;
  localparam int BIT_W     = 5;
  localparam int VALUE_W   = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT,
    ST_FINISH
  } cbr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             eval;
    logic             commit;
    logic             out_load;
    logic [BIT_W-1:0] bit_idx;
  } cbr_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/cbr_ctrl.sv =====
// Sequencer for the cube root search: accepts a request, steps through the
// root bits with an evaluate and a commit state each, then loads the result.
// Depends on cbr_pkg.
`default_nettype none

module cbr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cbr_pkg::cbr_cmd_t    cmd
);
  import cbr_pkg::*;

  cbr_state_t       state_r, state_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.bit_idx   = bit_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          bit_nxt   = BIT_W'(ROOT_BITS - 1);
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        if (bit_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          bit_nxt   = bit_r - 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_FINISH: begin
        // Hold the finished root until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/cbr_dp.sv =====
// Datapath of the cube root search: remainder, running root, 3*root and
// 3*root^2 registers, the shared increment adder and the output register.
// Depends on cbr_pkg.
`default_nettype none

module cbr_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire cbr_pkg::cbr_cmd_t               cmd,
  input  wire logic [cbr_pkg::VALUE_W-1:0]     value,
  output logic signed [cbr_pkg::ROOT_BITS-1:0] root
);
  import cbr_pkg::*;

  localparam int M_W  = VALUE_W + 2 * FRAC_BITS;
  localparam int CW   = (M_W > 66) ? M_W : 66;
  localparam int F3_W = ROOT_BITS + 2;
  localparam int SQ_W = 2 * ROOT_BITS + 1;

  logic [M_W-1:0]       rem_r;
  logic [ROOT_BITS-1:0] f_r;
  logic [F3_W-1:0]      f3_r;
  logic [SQ_W-1:0]      sq3_r;
  logic [CW-1:0]        inc_r;
  logic                 neg_r;
  logic [ROOT_BITS-1:0] root_r;

  logic [VALUE_W-1:0]   mag;
  logic [BIT_W-1:0]     k;
  logic [BIT_W:0]       k1;
  logic [BIT_W+1:0]     k2;
  logic [BIT_W+1:0]     k3;
  logic [CW-1:0]        inc_nxt;
  logic [CW-1:0]        rem_ext;
  logic                 fits;
  logic [ROOT_BITS-1:0] cap_m1;
  logic [ROOT_BITS-1:0] cap;
  logic [ROOT_BITS-1:0] mag_up;
  logic [ROOT_BITS-1:0] root_nxt;

  assign mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
  assign k   = cmd.bit_idx;
  assign k1  = {1'b0, k} + 1'b1;
  assign k2  = {1'b0, k, 1'b0};
  assign k3  = {2'b00, k} + {1'b0, k, 1'b0};

  // (f+b)^3 - f^3 = 3f^2*b + 3f*b^2 + b^3; the last two terms never overlap.
  assign inc_nxt = (CW'(sq3_r) << k)
                 + ((CW'(f3_r) << k2) | (CW'(1) << k3));

  assign rem_ext = CW'(rem_r);
  // Once the root has reached the cap every further candidate is too large.
  assign fits    = !f_r[ROOT_BITS-1] && (inc_r <= rem_ext);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= {mag, {(2 * FRAC_BITS){1'b0}}};
      neg_r <= value[VALUE_W-1];
      f_r   <= '0;
      f3_r  <= '0;
      sq3_r <= '0;
    end else if (cmd.commit && fits) begin
      rem_r <= M_W'(rem_ext - inc_r);
      f_r   <= f_r | (ROOT_BITS'(1) << k);
      f3_r  <= f3_r + (F3_W'(3) << k);
      sq3_r <= sq3_r + ((SQ_W'(f3_r) << k1) | (SQ_W'(3) << k2));
    end
    if (cmd.eval) begin
      inc_r <= inc_nxt;
    end
    if (cmd.out_load) begin
      root_r <= root_nxt;
    end
  end

  assign cap    = ROOT_BITS'(1) << (ROOT_BITS - 1);
  assign cap_m1 = cap - 1'b1;
  // A negative radicand rounds the magnitude up unless it was an exact cube.
  assign mag_up = f_r[ROOT_BITS-1] ? cap :
                  ((rem_r == '0) ? f_r : f_r + 1'b1);

  always_comb begin
    if (neg_r) begin
      root_nxt = ~mag_up + 1'b1;
    end else begin
      root_nxt = f_r[ROOT_BITS-1] ? cap_m1 : f_r;
    end
  end

  assign root = root_r;

endmodule

`default_nettype wire

// ===== rtl/cube_root_bisection_unit.sv =====
// Top level of the cube root bisection unit: stream ports, controller and
// datapath. Depends on cbr_pkg, cbr_ctrl and cbr_dp.
//
//   channel | direction | payload
//   in_     | slave     | in_tdata[31:0]  value, signed Q.FRAC_BITS radicand
//   out_    | master    | out_tdata[21:0] root, signed Q.FRAC_BITS floor cube root
//
// A request is taken in the idle cycle, where the datapath also loads it. The
// 22 root bits then pass each through an evaluate and a commit state on the shared
// increment adder, and the finish state forms the signed root; no new request is
// taken until the sequencer has returned to idle.
// Reset clears the sequencer and the output valid flag only.
// The result waits in an output register; the next request is accepted while
// it waits, and the search stalls at its end only if that register is full.
`default_nettype none

module cube_root_bisection_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [21:0] root, [23:22] zero
);
  import cbr_pkg::*;

  cbr_cmd_t                    cmd;
  logic signed [ROOT_BITS-1:0] root;

  cbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  cbr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk   (clk),
    .cmd   (cmd),
    .value (in_tdata[VALUE_W-1:0]),
    .root  (root)
  );

  assign out_tdata = {{(24 - ROOT_BITS){1'b0}}, root};

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending result");

  // An accepted request keeps the unit busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while a search is running");

  // Every commit is preceded by an evaluate of the same bit.
  a_commit_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> ($past(cmd.eval) && $stable(cmd.bit_idx)))
    else $error("commit without a matching evaluate");

endmodule

`default_nettype wire

// ===== sim/tb_cube_root_bisection_unit.sv =====
// Self-checking testbench for cube_root_bisection_unit: directed and random radicands,
// a floor cube root predictor, random idling on both streams and long output back-pressure.
// Depends on cbr_pkg and the RTL of cube_root_bisection_unit.
`default_nettype none

module tb_cube_root_bisection_unit;

  import cbr_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_REQS = 1150;
  localparam logic [ROOT_BITS:0] MAG_CAP = (ROOT_BITS + 1)'(1) << (ROOT_BITS - 1);

  typedef logic signed [ROOT_BITS-1:0] root_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    int unsigned        gap;
  } radicand_req_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [21:0] root, [23:22] zero

  radicand_req_t pending_radicands[$];
  root_t         roots_expected[$];

  int unsigned error_count = 0;
  int unsigned radicands_sent = 0;
  int unsigned negative_sent = 0;
  int unsigned roots_checked = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned gap_count = 0;
  int unsigned ready_wait = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  logic        hung = 1'b0;

  cube_root_bisection_unit #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Greatest grid value whose cube does not exceed the radicand, saturated to the root width.
  function automatic root_t floor_cube_root(input logic [VALUE_W-1:0] v);
    logic               neg;
    logic [VALUE_W:0]   mag;
    logic [95:0]        scaled;
    logic [ROOT_BITS:0] f;
    logic [ROOT_BITS:0] t;
    logic [ROOT_BITS:0] c;
    logic [95:0]        t_cubed;
    logic [ROOT_BITS:0] res;
    neg = v[VALUE_W-1];
    mag = neg ? ((VALUE_W + 1)'(1) << VALUE_W) - {1'b0, v} : {1'b0, v};
    scaled = 96'(mag) << (2 * FRAC_BITS);
    f = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      t = f | ((ROOT_BITS + 1)'(1) << b);
      t_cubed = 96'(t) * 96'(t) * 96'(t);
      if (t <= MAG_CAP && t_cubed <= scaled) f = t;
    end
    if (!neg) begin
      res = (f > MAG_CAP - 1'b1) ? MAG_CAP - 1'b1 : f;
    end else begin
      // A negative radicand rounds its magnitude up unless it is an exact cube.
      if (f >= MAG_CAP) c = MAG_CAP;
      else if (96'(f) * 96'(f) * 96'(f) == scaled) c = f;
      else c = f + 1'b1;
      res = -c;
    end
    return root_t'(res[ROOT_BITS-1:0]);
  endfunction

  function automatic logic [VALUE_W-1:0] random_radicand();
    logic [VALUE_W-1:0] v;
    int unsigned        k;
    longint             c;
    k = $urandom_range(0, 1023);
    c = 2 * longint'(k) * longint'(k) * longint'(k);
    case ($urandom_range(0, 9))
      5, 6:    v = $urandom >> $urandom_range(0, 31);
      7, 8:    v = c[VALUE_W-1:0];
      9:       v = c[VALUE_W-1:0] + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 9) >= 5 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Request driver: presents pending radicands, each after its own idle gap.
  always @(posedge clk) begin : driver
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      gap_count = 0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        roots_expected = {roots_expected, floor_cube_root(in_tdata)};
        radicands_sent++;
        if (in_tdata[31]) negative_sent++;
        next_valid = 1'b0;
      end else if (in_tvalid) begin
        input_stall_cycles++;
      end
      if (!next_valid && pending_radicands.size() > 0) begin
        if (gap_count < pending_radicands[0].gap) begin
          gap_count++;
        end else begin
          in_tdata <= pending_radicands[0].value;
          next_valid = 1'b1;
          gap_count = 0;
          pending_radicands.delete(0);
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // Result monitor and receiver: checks each root and paces out_tready.
  always @(posedge clk) begin : monitor
    logic  ready_next;
    root_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      ready_next = out_tready;
      if (out_tvalid && out_tready) begin
        if (roots_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected root %h", out_tdata));
        end else begin
          want = roots_expected.pop_front();
          if (root_t'(out_tdata[ROOT_BITS-1:0]) !== want)
            report_mismatch($sformatf("root %0d: got %h, expected %h", roots_checked,
                                      out_tdata[ROOT_BITS-1:0], want));
          if (out_tdata[23:ROOT_BITS] !== '0)
            report_mismatch($sformatf("root %0d: padding bits %b", roots_checked,
                                      out_tdata[23:ROOT_BITS]));
        end
        roots_checked++;
        // Twice in the run the receiver stalls long enough for the input to back up.
        if (roots_checked == 150 || roots_checked == 650) begin
          hold_left = HOLD_CYCLES;
          ready_next = 1'b0;
        end else begin
          if ((roots_checked >= 300 && roots_checked < 400) ||
              (roots_checked >= 800 && roots_checked < 900))
            ready_wait = 0;
          else
            ready_wait = $urandom_range(0, 19);
          ready_next = (ready_wait == 0);
        end
      end else if (hold_left > 0) begin
        hold_left--;
        ready_next = (hold_left == 0);
      end else if (!out_tready) begin
        if (ready_wait > 0) ready_wait--;
        ready_next = (ready_wait == 0);
      end
      out_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) hung <= 1'b1;
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] directed[$];
    radicand_req_t      req;
    int unsigned        n_directed;
    // Zero, unit steps, the range ends, exact cubes on both sides and their neighbors.
    directed = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFE,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 32'h0001_0000, -32'h0001_0000, 32'h0008_0000, -32'h0008_0000,
                 32'h0007_FFFF, -32'h0007_FFFF, 32'h001B_0000, -32'h001B_0000,
                 32'h0000_2000, -32'h0000_2000, 32'h0000_1FFF, 32'h03E8_0000,
                 -32'h03E8_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    n_directed = directed.size();
    foreach (directed[i]) begin
      req.value = directed[i];
      req.gap   = $urandom_range(0, 19);
      pending_radicands = {pending_radicands, req};
    end
    for (int i = 0; i < RANDOM_REQS; i++) begin
      req.value = random_radicand();
      req.gap   = ((i >= 300 && i < 400) || (i >= 800 && i < 900)) ? 0 : $urandom_range(0, 19);
      pending_radicands = {pending_radicands, req};
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (!hung && !(pending_radicands.size() == 0 && !in_tvalid &&
                      roots_expected.size() == 0))
      @(negedge clk);
    if (!hung) repeat (DRAIN_WAIT) @(negedge clk);
    if (roots_expected.size() != 0)
      report_mismatch($sformatf("%0d roots never arrived", roots_expected.size()));

    $display("Sent %0d radicands (%0d directed, %0d negative), checked %0d cube roots.",
             radicands_sent, n_directed, negative_sent, roots_checked);
    $display("Offered requests waited %0d cycles in all, through busy searches and held output.",
             input_stall_cycles);
    if (!hung && error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
